/* rtl/xks_pkg.sv */
// ----------------------------------------------------------------------------
// xks_pkg: shared types and constants for the XOR key search
// Message length limit, counter widths and the queue entry type.
// ----------------------------------------------------------------------------
package xks_pkg;

  localparam int unsigned MaxBytes  = 65536;
  localparam int unsigned NumKeys   = 255;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned ScoreW    = 17;
  localparam int unsigned SeenW     = $clog2(MaxBytes + 1);

  localparam logic [ScoreW-1:0] ScoreMax = {ScoreW{1'b1}};

  // One classified byte on its way from the front to the back.
  typedef struct packed {
    logic [ByteW-1:0] cipher_byte;
    logic             last;
    logic             score_en;   // byte lies within the message length limit
  } xks_item_t;

endpackage

/* rtl/xks_front.sv */
// ----------------------------------------------------------------------------
// xks_front: byte intake
// Accept bytes, count them per message and mark those past the length limit.
// ----------------------------------------------------------------------------
module xks_front
  import xks_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [ByteW-1:0] s_axis_tdata,
  input  logic             s_axis_tlast,
  input  logic             q_full_i,
  output logic             q_push_o,
  output xks_item_t        q_item_o
);

  logic [SeenW-1:0] seen_q, seen_d;
  logic             in_range;

  assign s_axis_tready = !q_full_i;
  assign q_push_o      = s_axis_tvalid && s_axis_tready;
  assign in_range      = seen_q < SeenW'(MaxBytes);

  assign q_item_o.cipher_byte = s_axis_tdata;
  assign q_item_o.last        = s_axis_tlast;
  assign q_item_o.score_en    = in_range;

  always_comb begin
    seen_d = seen_q;
    if (q_push_o) begin
      if (s_axis_tlast) begin
        seen_d = '0;
      end else if (in_range) begin
        seen_d = seen_q + SeenW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else begin
      seen_q <= seen_d;
    end
  end

endmodule

/* rtl/xks_queue.sv */
// ----------------------------------------------------------------------------
// xks_queue: two-entry queue between intake and scoring
// Flip-flop FIFO; lets the intake keep taking bytes while scoring is busy.
// ----------------------------------------------------------------------------
module xks_queue
  import xks_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  xks_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output xks_item_t item_o
);

  xks_item_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

endmodule

/* rtl/xks_back.sv */
// ----------------------------------------------------------------------------
// xks_back: key counter bank and best-key scan
// Update all key counters per byte; on the last byte rotate the bank past a
// single comparator, clearing it on the way, and register the result.
// ----------------------------------------------------------------------------
module xks_back
  import xks_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  xks_item_t            q_item_i,
  output logic                 q_pop_o,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [ByteW-1:0]     best_key_o,
  output logic [ScoreW-1:0]    best_count_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  localparam logic [ByteW-1:0] LastIdx = ByteW'(NumKeys - 1);

  function automatic logic is_letter_or_space(logic [ByteW-1:0] c);
    logic [ByteW-1:0] lower;
    lower = c | 8'h20;
    return (c == 8'h20) ||
           (!c[7] && lower >= 8'h61 && lower <= 8'h7a);
  endfunction

  logic                 state_q, state_d;
  logic [ScoreW-1:0]    score_q [NumKeys];
  logic [ScoreW-1:0]    score_d [NumKeys];
  logic [ByteW-1:0]     scan_idx_q, scan_idx_d;
  logic [ByteW-1:0]     best_key_q, best_key_d;
  logic [ScoreW-1:0]    best_count_q, best_count_d;
  logic                 out_valid_q, out_valid_d;
  logic [ByteW-1:0]     out_key_q;
  logic [ScoreW-1:0]    out_count_q;
  logic                 out_load;
  logic                 out_free;
  logic                 scan_last;
  logic                 scan_step;
  logic                 better;
  logic [ByteW-1:0]     cand_key;
  logic [ScoreW-1:0]    cand_count;

  assign q_pop_o   = (state_q == ST_IDLE) && q_valid_i;
  assign out_free  = !out_valid_q || m_axis_tready;
  assign scan_last = scan_idx_q == LastIdx;
  assign scan_step = (state_q == ST_SCAN) && (!scan_last || out_free);
  assign out_load  = scan_step && scan_last;

  // Strictly greater keeps the lower key on a tie.
  assign better     = score_q[0] > best_count_q;
  assign cand_key   = better ? (scan_idx_q + ByteW'(1)) : best_key_q;
  assign cand_count = better ? score_q[0] : best_count_q;

  assign m_axis_tvalid = out_valid_q;
  assign best_key_o    = out_key_q;
  assign best_count_o  = out_count_q;

  always_comb begin
    state_d      = state_q;
    scan_idx_d   = scan_idx_q;
    best_key_d   = best_key_q;
    best_count_d = best_count_q;
    for (int k = 0; k < NumKeys; k++) begin
      score_d[k] = score_q[k];
    end

    unique case (state_q)
      ST_IDLE: begin
        if (q_pop_o) begin
          if (q_item_i.score_en) begin
            for (int k = 0; k < NumKeys; k++) begin
              if (is_letter_or_space(q_item_i.cipher_byte ^ ByteW'(k + 1)) &&
                  score_q[k] != ScoreMax) begin
                score_d[k] = score_q[k] + ScoreW'(1);
              end
            end
          end
          if (q_item_i.last) begin
            state_d      = ST_SCAN;
            scan_idx_d   = '0;
            best_key_d   = '0;
            best_count_d = '0;
          end
        end
      end
      ST_SCAN: begin
        if (scan_step) begin
          // Rotate the bank toward the comparator and shift in cleared counts.
          for (int k = 0; k < NumKeys - 1; k++) begin
            score_d[k] = score_q[k + 1];
          end
          score_d[NumKeys - 1] = '0;
          best_key_d   = cand_key;
          best_count_d = cand_count;
          scan_idx_d   = scan_idx_q + ByteW'(1);
          if (scan_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_idx_q   <= scan_idx_d;
    best_key_q   <= best_key_d;
    best_count_q <= best_count_d;
    if (out_load) begin
      out_key_q   <= cand_key;
      out_count_q <= cand_count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      for (int k = 0; k < NumKeys; k++) begin
        score_q[k] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      for (int k = 0; k < NumKeys; k++) begin
        score_q[k] <= score_d[k];
      end
    end
  end

endmodule

/* rtl/xor_key_search_letter_score.sv */
// ----------------------------------------------------------------------------
// xor_key_search_letter_score: single-byte XOR key search by letter score
// Scores every key 1..255 over a byte stream and reports the best key.
// ----------------------------------------------------------------------------
// A message enters one ciphertext byte per transfer on the slave stream, the
// final byte marked with tlast. For each key 1..255 the block counts the bytes
// that decrypt to an ASCII letter of either case or a space; only the first
// MaxBytes bytes of a message are scored, and each count saturates at 17 bits.
// After the last byte one result leaves on the master stream (also marked with
// tlast): the lowest key with the highest count and that count, or key 0 and
// count 0 if nothing scored. Bytes are taken at one per cycle while the queue
// has room. A byte marked last starts a scan: the counter bank is rotated past
// one comparator, one key per cycle, and cleared as it goes, so no separate
// clearing pass follows reset or a message. A two-entry queue keeps the intake
// open for two more bytes during that scan, and the result waits in an output
// register so a stalled sink holds only the end of the next scan.
// ----------------------------------------------------------------------------
module xor_key_search_letter_score
  import xks_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Slave stream: ciphertext bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] cipher_byte
  input  logic        s_axis_tlast,   // last
  // Master stream: search results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] best_key, [24:8] best_count, [31:25] zero
  output logic        m_axis_tlast
);

  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_valid;
  xks_item_t          q_in_item;
  xks_item_t          q_out_item;
  logic [ByteW-1:0]   best_key;
  logic [ScoreW-1:0]  best_count;

  // Intake: accept bytes and tag those within the length limit.
  xks_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_item_o      (q_in_item)
  );

  // Decouple intake from scoring so either side can stall alone.
  xks_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out_item)
  );

  // Scoring: per-key counters, end-of-message scan and result register.
  xks_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (q_out_item),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .best_key_o    (best_key),
    .best_count_o  (best_count)
  );

  // Each result closes its message, so every result transfer carries tlast.
  assign m_axis_tlast = 1'b1;
  assign m_axis_tdata = {7'd0, best_count, best_key};

endmodule

/* bench/tb_xor_key_search_letter_score.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_xor_key_search_letter_score: stream testbench for the XOR key search
// Feeds ciphertext messages into the slave stream and scores every key 1..255
// in a local model of the block. Each result on the master stream is compared
// with the oldest predicted best key and count. The stimulus covers byte
// extremes, ties and random plain or noise messages, with random idle bursts
// on both streams.
// ----------------------------------------------------------------------------
module tb_xor_key_search_letter_score;
  import xks_pkg::*;

  // Cycles with no transfer on either stream before the run is given up.
  // A last byte costs a full scan of the counter bank plus sink stalls, so this is loose.
  localparam int unsigned IdleLimit  = 3000;
  // Quiet cycles after the final result, to catch any stray extra result.
  localparam int unsigned ScanCycles = 300;
  localparam int unsigned RandBytes  = 1700;

  localparam logic [ByteW-1:0] ChSpace = " ";
  localparam logic [ByteW-1:0] ChLowA  = "a";
  localparam logic [ByteW-1:0] ChLowZ  = "z";
  localparam logic [ByteW-1:0] ChUpA   = "A";

  // One pending ciphertext byte; drain holds it back until no result is due.
  typedef struct {
    logic [ByteW-1:0] cipher_byte;
    logic             last;
    bit               drain;
  } msg_byte_t;

  typedef struct packed {
    logic [ByteW-1:0]  best_key;
    logic [ScoreW-1:0] best_count;
  } key_pick_t;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [7:0] cipher_byte
  logic        s_axis_tlast  = 1'b0; // last
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // [7:0] best_key, [24:8] best_count, [31:25] zero
  logic        m_axis_tlast;

  // Local copy of the per-key letter counters and the message length.
  logic [ScoreW-1:0] key_tally [1:NumKeys];
  int unsigned       tally_seen;

  msg_byte_t   cipher_q[$];   // bytes not yet transferred, front is on the bus
  key_pick_t   pick_q[$];     // predicted results not yet seen
  bit          idle_on = 1'b1;
  bit          in_fire;
  bit          out_fire;
  int unsigned in_gap;
  int unsigned out_gap;
  int unsigned stall_cnt;
  int unsigned err_cnt;
  int unsigned n_bytes;
  int unsigned n_msgs;
  int unsigned n_results;

  xor_key_search_letter_score i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // An ASCII letter of either case or a space; the top bit never counts.
  function automatic bit is_text(input logic [ByteW-1:0] c);
    logic [ByteW-1:0] lower;
    lower = c | 8'h20;
    return (c == ChSpace) || (c < 8'h80 && lower >= ChLowA && lower <= ChLowZ);
  endfunction

  // Draw a random letter or space, the content of a plaintext message.
  function automatic logic [ByteW-1:0] text_char();
    int unsigned pick;
    pick = $urandom_range(0, 52);
    if (pick == 0) return ChSpace;
    if (pick <= 26) return ChUpA + ByteW'(pick - 1);
    return ChLowA + ByteW'(pick - 27);
  endfunction

  task automatic clear_tally();
    for (int k = 1; k <= NumKeys; k++) key_tally[k] = '0;
    tally_seen = 0;
  endtask

  task automatic add_byte(input logic [ByteW-1:0] b, input logic last, input bit drain);
    msg_byte_t item;
    item.cipher_byte = b;
    item.last        = last;
    item.drain       = drain;
    cipher_q.push_back(item);
    if (last) n_msgs++;
  endtask

  // Score one transferred byte under every key; on the last byte pick the
  // winner (strictly greater, so the lower key keeps a tie) and clear.
  task automatic score_byte(input msg_byte_t item);
    key_pick_t pick;
    if (tally_seen < MaxBytes) begin
      for (int k = 1; k <= NumKeys; k++) begin
        if (is_text(item.cipher_byte ^ k[ByteW-1:0]) && key_tally[k] < ScoreMax)
          key_tally[k]++;
      end
      tally_seen++;
    end
    if (item.last) begin
      pick = '0;
      for (int k = 1; k <= NumKeys; k++) begin
        if (key_tally[k] > pick.best_count) begin
          pick.best_count = key_tally[k];
          pick.best_key   = k[ByteW-1:0];
        end
      end
      pick_q.push_back(pick);
      clear_tally();
    end
  endtask

  // Slave-side driver: hold the byte until it transfers, else idle a burst
  // or present the front of the queue. A drain byte waits for all results.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !in_fire) begin
      s_axis_tvalid <= 1'b1;
    end else if (in_gap > 0) begin
      in_gap--;
      s_axis_tvalid <= 1'b0;
    end else if (cipher_q.size() == 0) begin
      s_axis_tvalid <= 1'b0;
    end else if (cipher_q[0].drain && pick_q.size() != 0) begin
      s_axis_tvalid <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      in_gap = $urandom_range(0, 9);
      s_axis_tvalid <= 1'b0;
    end else begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= cipher_q[0].cipher_byte;
      s_axis_tlast  <= cipher_q[0].last;
    end
  end

  // Master-side sink: stall in random bursts while idling is on.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_gap = $urandom_range(0, 9);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Monitor: advance the model on each input transfer, check each result
  // transfer against the oldest prediction, and watch for a stuck block.
  always @(posedge clk_i) begin
    key_pick_t want;
    msg_byte_t item;
    if (rst_ni) begin
      in_fire  = s_axis_tvalid && s_axis_tready;
      out_fire = m_axis_tvalid && m_axis_tready;
      if (in_fire) begin
        item = cipher_q.pop_front();
        score_byte(item);
        n_bytes++;
      end
      if (out_fire) begin
        if (pick_q.size() == 0) begin
          err_cnt++;
          $error("result with none expected: tdata %h", m_axis_tdata);
        end else begin
          want = pick_q.pop_front();
          n_results++;
          if (m_axis_tdata[7:0] !== want.best_key) begin
            err_cnt++;
            $error("best_key: expected %0d, actual %0d", want.best_key, m_axis_tdata[7:0]);
          end
          if (m_axis_tdata[24:8] !== want.best_count) begin
            err_cnt++;
            $error("best_count: expected %0d, actual %0d",
                   want.best_count, m_axis_tdata[24:8]);
          end
          if (m_axis_tdata[31:25] !== '0) begin
            err_cnt++;
            $error("tdata pad: expected 0, actual %h", m_axis_tdata[31:25]);
          end
          if (m_axis_tlast !== 1'b1) begin
            err_cnt++;
            $error("tlast: expected 1, actual %b", m_axis_tlast);
          end
        end
      end
      if (in_fire || out_fire) stall_cnt = 0;
      else stall_cnt++;
      if (stall_cnt >= IdleLimit) begin
        $display("watchdog: no transfer for %0d cycles, %0d results pending",
                 IdleLimit, pick_q.size());
        $display("tb_xor_key_search_letter_score: errors");
        $finish;
      end
    end
  end

  initial begin
    string       hello;
    int unsigned len;
    int unsigned rand_cnt;
    logic [7:0]  key;
    logic [7:0]  b;
    bit          plain;
    bit          drain;
    clear_tally();
    hello = "Hello World";

    // Single-byte messages at the byte extremes: each is a wide tie that the
    // lowest scoring key must win.
    add_byte(8'h00, 1'b1, 1'b0);
    add_byte(8'hFF, 1'b1, 1'b0);
    // Top bit set and just below it.
    add_byte(8'h80, 1'b0, 1'b0);
    add_byte(8'h7F, 1'b1, 1'b0);
    // A real sentence under a known key.
    for (int i = 0; i < hello.len(); i++)
      add_byte(hello[i] ^ 8'h5A, i == hello.len() - 1, 1'b0);
    // Space and both letter cases in the clear; wait for a drained block first.
    add_byte(ChSpace, 1'b0, 1'b1);
    add_byte(ChUpA, 1'b0, 1'b0);
    add_byte(ChLowZ, 1'b1, 1'b0);

    // Random messages: mostly plaintext under a random key with a little
    // noise, the rest random bytes; a few long ones.
    rand_cnt = 0;
    while (rand_cnt < RandBytes) begin
      len   = ($urandom_range(0, 15) == 0) ? $urandom_range(41, 160) : $urandom_range(1, 40);
      plain = $urandom_range(0, 9) < 7;
      key   = 8'($urandom_range(1, 255));
      drain = $urandom_range(0, 24) == 0;
      for (int i = 0; i < len; i++) begin
        if (plain && $urandom_range(0, 9) != 0) b = text_char() ^ key;
        else b = 8'($urandom_range(0, 255));
        add_byte(b, i == len - 1, drain && i == 0);
      end
      rand_cnt += len;
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Run the tail of the stimulus at full rate on both sides.
    while (cipher_q.size() >= 150) @(posedge clk_i);
    idle_on = 1'b0;
    while (cipher_q.size() != 0) @(posedge clk_i);
    while (pick_q.size() != 0) @(posedge clk_i);
    repeat (ScanCycles) @(posedge clk_i);

    $display("covered %0d bytes in %0d messages, %0d results checked", n_bytes, n_msgs,
             n_results);
    $display("including byte extremes, ties, drained pauses and random text or noise");
    if (err_cnt == 0) begin
      $display("tb_xor_key_search_letter_score: clean");
    end else begin
      $display("tb_xor_key_search_letter_score: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/xks_pkg.sv
rtl/xks_front.sv
rtl/xks_queue.sv
rtl/xks_back.sv
rtl/xor_key_search_letter_score.sv
bench/tb_xor_key_search_letter_score.sv
